/* rtl/rk4sd_pkg.sv */
package rk4sd_pkg;

   localparam int WORD_W = 64;
   localparam int STEP_W = 63;
   localparam int SRC_W  = 5;
   localparam int PC_W   = 6;
   localparam int CSR_IDX_W = 3;

   localparam logic [PC_W-1:0] PROG_LAST = 6'd41;

   localparam logic [CSR_IDX_W-1:0] CSR_LINEAR   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CUBIC    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_MASS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TOL      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ADAPTIVE = 3'd4;

   localparam logic [WORD_W-1:0] RST_INV_MASS = 64'd281474976710656;
   localparam logic [STEP_W-1:0] RST_TOL      = 63'd281474977;

   localparam logic [3:0] DIVISOR_SIXTH   = 4'd6;
   localparam logic [3:0] DIVISOR_FIFTEEN = 4'd15;

   // floor(n/d) = (n * RECIP) >> (64 + RECIP_SHIFT), exact for any 64-bit n
   localparam logic [WORD_W-1:0] RECIP_SIXTH         = 64'hAAAA_AAAA_AAAA_AAAB;
   localparam logic [1:0]        RECIP_SHIFT_SIXTH   = 2'd2;
   localparam logic [WORD_W-1:0] RECIP_FIFTEEN       = 64'h8888_8888_8888_8889;
   localparam logic [1:0]        RECIP_SHIFT_FIFTEEN = 2'd3;

   localparam logic [WORD_W-1:0] WORD_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [WORD_W-1:0] WORD_MIN = 64'h8000_0000_0000_0000;
   localparam logic [STEP_W-1:0] STEP_MAX = 63'h7FFF_FFFF_FFFF_FFFF;

   // operand codes: scratch memory below 16, dedicated sources from 16 up
   localparam logic [SRC_W-1:0] SRC_Y     = 5'd0;
   localparam logic [SRC_W-1:0] SRC_T1    = 5'd1;
   localparam logic [SRC_W-1:0] SRC_T2    = 5'd2;
   localparam logic [SRC_W-1:0] SRC_T3    = 5'd3;
   localparam logic [SRC_W-1:0] SRC_T4    = 5'd4;
   localparam logic [SRC_W-1:0] SRC_K1    = 5'd5;
   localparam logic [SRC_W-1:0] SRC_K2    = 5'd6;
   localparam logic [SRC_W-1:0] SRC_K3    = 5'd7;
   localparam logic [SRC_W-1:0] SRC_K4    = 5'd8;
   localparam logic [SRC_W-1:0] SRC_Y0    = 5'd16;
   localparam logic [SRC_W-1:0] SRC_A1    = 5'd17;
   localparam logic [SRC_W-1:0] SRC_A3    = 5'd18;
   localparam logic [SRC_W-1:0] SRC_IM    = 5'd19;
   localparam logic [SRC_W-1:0] SRC_HALF  = 5'd20;
   localparam logic [SRC_W-1:0] SRC_HS    = 5'd21;
   localparam logic [SRC_W-1:0] SRC_SIXTH = 5'd22;
   localparam logic [SRC_W-1:0] SRC_ZERO  = 5'd23;
   localparam logic [SRC_W-1:0] DST_RES   = 5'd16;

   typedef enum logic [1:0] {
      OP_ADD,
      OP_NEG,
      OP_MUL
   } op_type;

   typedef struct packed {
      op_type           op;
      logic [SRC_W-1:0] a;
      logic [SRC_W-1:0] b;
      logic [SRC_W-1:0] dst;
   } uop_type;

   typedef enum logic [1:0] {
      SUGG_KEEP,
      SUGG_DOUBLE
   } sugg_type;

   typedef struct packed {
      logic       load;
      logic       pass_setup;
      logic [1:0] pass;
      logic       div_start;
      logic       div_err;
      logic       uop_start;
      uop_type    uop;
      logic       latch_whole;
      logic       latch_two_half;
      logic       halve_h;
      logic       finish;
      sugg_type   sugg;
      logic       limit;
   } cmd_type;

   typedef struct packed {
      logic uop_done;
      logic div_done;
      logic err_gt;
      logic err_lt;
      logic adaptive;
      logic out_free;
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SETUP,
      ST_DIV6,
      ST_ISSUE,
      ST_WAIT,
      ST_PASS_END,
      ST_ERR_DIV,
      ST_DECIDE,
      ST_FINISH
   } state_type;

   function automatic uop_type mk_uop(input op_type op, input logic [SRC_W-1:0] a,
                                      input logic [SRC_W-1:0] b,
                                      input logic [SRC_W-1:0] dst);
      uop_type u;
      u.op  = op;
      u.a   = a;
      u.b   = b;
      u.dst = dst;
      return u;
   endfunction

   // f(y) = -(a1*y + a3*y^3) * (1/m), y in SRC_Y
   function automatic uop_type deriv_uop(input logic [2:0] off, input logic [SRC_W-1:0] dst);
      uop_type u;
      case (off)
         3'd0: u = mk_uop(OP_MUL, SRC_Y, SRC_Y, SRC_T1);
         3'd1: u = mk_uop(OP_MUL, SRC_T1, SRC_Y, SRC_T1);
         3'd2: u = mk_uop(OP_MUL, SRC_A1, SRC_Y, SRC_T2);
         3'd3: u = mk_uop(OP_MUL, SRC_A3, SRC_T1, SRC_T1);
         3'd4: u = mk_uop(OP_ADD, SRC_T2, SRC_T1, SRC_T1);
         3'd5: u = mk_uop(OP_NEG, SRC_T1, SRC_T1, SRC_T1);
         default: u = mk_uop(OP_MUL, SRC_T1, SRC_IM, dst);
      endcase
      return u;
   endfunction

   // one RK4 step from SRC_Y0 with step SRC_HS, result to DST_RES
   function automatic uop_type prog_uop(input logic [PC_W-1:0] pc);
      uop_type u;
      if (pc == 6'd0) begin
         u = mk_uop(OP_ADD, SRC_Y0, SRC_ZERO, SRC_Y);
      end else if (pc <= 6'd7) begin
         u = deriv_uop(3'(pc - 6'd1), SRC_K1);
      end else if (pc == 6'd8) begin
         u = mk_uop(OP_MUL, SRC_HALF, SRC_K1, SRC_T3);
      end else if (pc == 6'd9) begin
         u = mk_uop(OP_ADD, SRC_Y0, SRC_T3, SRC_Y);
      end else if (pc <= 6'd16) begin
         u = deriv_uop(3'(pc - 6'd10), SRC_K2);
      end else if (pc == 6'd17) begin
         u = mk_uop(OP_MUL, SRC_HALF, SRC_K2, SRC_T3);
      end else if (pc == 6'd18) begin
         u = mk_uop(OP_ADD, SRC_Y0, SRC_T3, SRC_Y);
      end else if (pc <= 6'd25) begin
         u = deriv_uop(3'(pc - 6'd19), SRC_K3);
      end else if (pc == 6'd26) begin
         u = mk_uop(OP_MUL, SRC_HS, SRC_K3, SRC_T3);
      end else if (pc == 6'd27) begin
         u = mk_uop(OP_ADD, SRC_Y0, SRC_T3, SRC_Y);
      end else if (pc <= 6'd34) begin
         u = deriv_uop(3'(pc - 6'd28), SRC_K4);
      end else if (pc == 6'd35) begin
         u = mk_uop(OP_ADD, SRC_K2, SRC_K2, SRC_T3);
      end else if (pc == 6'd36) begin
         u = mk_uop(OP_ADD, SRC_K1, SRC_T3, SRC_T3);
      end else if (pc == 6'd37) begin
         u = mk_uop(OP_ADD, SRC_K3, SRC_K3, SRC_T4);
      end else if (pc == 6'd38) begin
         u = mk_uop(OP_ADD, SRC_T4, SRC_K4, SRC_T4);
      end else if (pc == 6'd39) begin
         u = mk_uop(OP_ADD, SRC_T3, SRC_T4, SRC_T3);
      end else if (pc == 6'd40) begin
         u = mk_uop(OP_MUL, SRC_SIXTH, SRC_T3, SRC_T3);
      end else begin
         u = mk_uop(OP_ADD, SRC_Y0, SRC_T3, DST_RES);
      end
      return u;
   endfunction

endpackage

/* rtl/rk4sd_mul.sv */
module rk4sd_mul #(
   parameter int FRAC_BITS = 48
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] a,
   input  logic [63:0] b,
   output logic        done,
   output logic [63:0] result,
   output logic        sat
);

   logic         busy_ff;
   logic [2:0]   cnt_ff;
   logic [63:0]  ma_ff;
   logic [63:0]  mb_ff;
   logic         neg_ff;
   logic [63:0]  pp_ff;
   logic [6:0]   sh_ff;
   logic [127:0] acc_ff;
   logic [31:0]  op_x;
   logic [31:0]  op_y;
   logic [6:0]   sh_in;
   logic [63:0]  qlo;
   logic         qhi_nz;

   always_comb begin
      case (cnt_ff[1:0])
         2'd0: begin
            op_x = ma_ff[31:0];  op_y = mb_ff[31:0];  sh_in = 7'd0;
         end
         2'd1: begin
            op_x = ma_ff[31:0];  op_y = mb_ff[63:32]; sh_in = 7'd32;
         end
         2'd2: begin
            op_x = ma_ff[63:32]; op_y = mb_ff[31:0];  sh_in = 7'd32;
         end
         default: begin
            op_x = ma_ff[63:32]; op_y = mb_ff[63:32]; sh_in = 7'd64;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= 3'd0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= 3'd0;
      end else if (busy_ff) begin
         if (cnt_ff == 3'd5) begin
            busy_ff <= 1'b0;
         end
         cnt_ff <= cnt_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         ma_ff  <= a[63] ? (64'd0 - a) : a;
         mb_ff  <= b[63] ? (64'd0 - b) : b;
         neg_ff <= a[63] ^ b[63];
         acc_ff <= 128'd0;
      end else if (busy_ff) begin
         if (cnt_ff < 3'd4) begin
            pp_ff <= 64'(op_x * op_y);
            sh_ff <= sh_in;
         end
         if (cnt_ff >= 3'd1 && cnt_ff <= 3'd4) begin
            acc_ff <= acc_ff + ({64'd0, pp_ff} << sh_ff);
         end
      end
   end

   assign done   = busy_ff && (cnt_ff == 3'd5);
   assign qlo    = acc_ff[FRAC_BITS+63:FRAC_BITS];
   assign qhi_nz = |acc_ff[127:FRAC_BITS+64];

   always_comb begin
      sat    = 1'b0;
      result = qlo;
      if (qhi_nz) begin
         sat    = 1'b1;
         result = neg_ff ? rk4sd_pkg::WORD_MIN : rk4sd_pkg::WORD_MAX;
      end else if (neg_ff) begin
         if (qlo > rk4sd_pkg::WORD_MIN) begin
            sat    = 1'b1;
            result = rk4sd_pkg::WORD_MIN;
         end else begin
            result = 64'd0 - qlo;
         end
      end else if (qlo[63]) begin
         sat    = 1'b1;
         result = rk4sd_pkg::WORD_MAX;
      end
   end

endmodule

/* rtl/rk4sd_div.sv */
module rk4sd_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [3:0]  divisor,
   output logic        done,
   output logic [63:0] quotient
);

   logic         busy_ff;
   logic [2:0]   cnt_ff;
   logic [63:0]  num_ff;
   logic [63:0]  rcp_ff;
   logic [1:0]   shift_ff;
   logic [63:0]  pp_ff;
   logic [6:0]   sh_ff;
   logic [127:0] acc_ff;
   logic [63:0]  rcp_sel;
   logic [1:0]   shift_sel;
   logic [31:0]  op_x;
   logic [31:0]  op_y;
   logic [6:0]   sh_in;
   logic [63:0]  prod_hi;

   // divide by a constant as a multiply by its rounded-up reciprocal
   always_comb begin
      case (divisor)
         rk4sd_pkg::DIVISOR_SIXTH: begin
            rcp_sel   = rk4sd_pkg::RECIP_SIXTH;
            shift_sel = rk4sd_pkg::RECIP_SHIFT_SIXTH;
         end
         default: begin
            rcp_sel   = rk4sd_pkg::RECIP_FIFTEEN;
            shift_sel = rk4sd_pkg::RECIP_SHIFT_FIFTEEN;
         end
      endcase
   end

   always_comb begin
      case (cnt_ff[1:0])
         2'd0: begin
            op_x = num_ff[31:0];  op_y = rcp_ff[31:0];  sh_in = 7'd0;
         end
         2'd1: begin
            op_x = num_ff[31:0];  op_y = rcp_ff[63:32]; sh_in = 7'd32;
         end
         2'd2: begin
            op_x = num_ff[63:32]; op_y = rcp_ff[31:0];  sh_in = 7'd32;
         end
         default: begin
            op_x = num_ff[63:32]; op_y = rcp_ff[63:32]; sh_in = 7'd64;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= 3'd0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= 3'd0;
      end else if (busy_ff) begin
         if (cnt_ff == 3'd5) begin
            busy_ff <= 1'b0;
         end
         cnt_ff <= cnt_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff   <= dividend;
         rcp_ff   <= rcp_sel;
         shift_ff <= shift_sel;
         acc_ff   <= 128'd0;
      end else if (busy_ff) begin
         if (cnt_ff < 3'd4) begin
            pp_ff <= 64'(op_x * op_y);
            sh_ff <= sh_in;
         end
         if (cnt_ff >= 3'd1 && cnt_ff <= 3'd4) begin
            acc_ff <= acc_ff + ({64'd0, pp_ff} << sh_ff);
         end
      end
   end

   assign prod_hi  = acc_ff[127:64];
   assign done     = busy_ff && (cnt_ff == 3'd5);
   assign quotient = prod_hi >> shift_ff;

endmodule

/* rtl/rk4sd_datapath.sv */
module rk4sd_datapath #(
   parameter int FRAC_BITS = 48
) (
   input  logic                  clock,
   input  logic                  reset,
   input  rk4sd_pkg::cmd_type    cmd,
   output rk4sd_pkg::status_type status,
   input  logic signed [63:0]    req_position,
   input  logic signed [63:0]    req_current_value,
   input  logic [62:0]           req_step_size,
   input  logic                  csr_valid,
   input  logic [2:0]            csr_index,
   input  logic [63:0]           csr_wdata,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic signed [63:0]    rsp_next_position,
   output logic signed [63:0]    rsp_next_value,
   output logic [62:0]           rsp_suggested_step,
   output logic [62:0]           rsp_accepted_step,
   output logic signed [63:0]    rsp_two_half_value,
   output logic                  rsp_halving_limit_hit,
   output logic                  rsp_saturated
);

   logic [63:0] a1_ff, a3_ff, im_ff;
   logic [62:0] tol_ff;
   logic        adapt_ff;
   logic [63:0] x_ff, v_ff, y0_ff, res_ff, whole_ff, two_half_ff;
   logic [62:0] h_ff, hcur_ff, sixth_ff;
   logic [63:0] err_ff;
   logic        sat_ff;
   logic        div_err_ff;
   logic [63:0] mem [0:15];
   logic [63:0] opa_ff, opb_ff;
   rk4sd_pkg::uop_type uop_ff;
   logic        rd_ff;
   logic        rsp_valid_ff;

   logic [62:0] hsel;
   logic [64:0] diff;
   logic [63:0] mag;
   logic [63:0] div_q;
   logic        div_done;
   logic        mul_done, mul_sat;
   logic [63:0] mul_res;
   logic [64:0] alu_add, alu_neg, alu_out;
   logic        wb_valid;
   logic [63:0] wb_data;
   logic        wb_sat;
   logic [64:0] pos_sum;
   logic [62:0] sugg_in;
   logic        dbl_sat;

   function automatic logic [64:0] sat_add(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) begin
         return {1'b1, a[63] ? rk4sd_pkg::WORD_MIN : rk4sd_pkg::WORD_MAX};
      end
      return {1'b0, s};
   endfunction

   function automatic logic [63:0] src_special(input logic [4:0] code, input logic [63:0] y0,
                                               input logic [63:0] a1, input logic [63:0] a3,
                                               input logic [63:0] im, input logic [62:0] hc,
                                               input logic [62:0] sx);
      logic [63:0] val;
      case (code)
         rk4sd_pkg::SRC_Y0:    val = y0;
         rk4sd_pkg::SRC_A1:    val = a1;
         rk4sd_pkg::SRC_A3:    val = a3;
         rk4sd_pkg::SRC_IM:    val = im;
         rk4sd_pkg::SRC_HALF:  val = {2'b00, hc[62:1]};
         rk4sd_pkg::SRC_HS:    val = {1'b0, hc};
         rk4sd_pkg::SRC_SIXTH: val = {1'b0, sx};
         default:              val = 64'd0;
      endcase
      return val;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         a1_ff    <= 64'd0;
         a3_ff    <= 64'd0;
         im_ff    <= 64'd1 << FRAC_BITS;
         tol_ff   <= rk4sd_pkg::RST_TOL;
         adapt_ff <= 1'b1;
      end else if (csr_valid) begin
         case (csr_index)
            rk4sd_pkg::CSR_LINEAR:   a1_ff    <= csr_wdata;
            rk4sd_pkg::CSR_CUBIC:    a3_ff    <= csr_wdata;
            rk4sd_pkg::CSR_INV_MASS: im_ff    <= csr_wdata;
            rk4sd_pkg::CSR_TOL:      tol_ff   <= csr_wdata[62:0];
            rk4sd_pkg::CSR_ADAPTIVE: adapt_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // divider: h/6 per pass, |two_half - whole|/15 per attempt
   assign hsel = (cmd.pass == 2'd0) ? h_ff : {1'b0, h_ff[62:1]};
   assign diff = {res_ff[63], res_ff} - {whole_ff[63], whole_ff};
   assign mag  = diff[64] ? 64'(65'd0 - diff) : diff[63:0];

   rk4sd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (cmd.div_err ? mag : {1'b0, hsel}),
      .divisor  (cmd.div_err ? rk4sd_pkg::DIVISOR_FIFTEEN : rk4sd_pkg::DIVISOR_SIXTH),
      .done     (div_done),
      .quotient (div_q)
   );

   rk4sd_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (rd_ff && uop_ff.op == rk4sd_pkg::OP_MUL),
      .a      (opa_ff),
      .b      (opb_ff),
      .done   (mul_done),
      .result (mul_res),
      .sat    (mul_sat)
   );

   assign alu_add = sat_add(opa_ff, opb_ff);
   assign alu_neg = (opa_ff == rk4sd_pkg::WORD_MIN) ? {1'b1, rk4sd_pkg::WORD_MAX}
                                                     : {1'b0, 64'd0 - opa_ff};

   always_comb begin
      case (uop_ff.op)
         rk4sd_pkg::OP_NEG: alu_out = alu_neg;
         default:           alu_out = alu_add;
      endcase
   end

   always_comb begin
      if (uop_ff.op == rk4sd_pkg::OP_MUL) begin
         wb_valid = mul_done;
         wb_data  = mul_res;
         wb_sat   = mul_sat;
      end else begin
         wb_valid = rd_ff;
         wb_data  = alu_out[63:0];
         wb_sat   = alu_out[64];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff <= 1'b0;
      end else begin
         rd_ff <= cmd.uop_start;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.uop_start) begin
         uop_ff <= cmd.uop;
         opa_ff <= cmd.uop.a[4] ? src_special(cmd.uop.a, y0_ff, a1_ff, a3_ff, im_ff,
                                              hcur_ff, sixth_ff)
                                : mem[cmd.uop.a[3:0]];
         opb_ff <= cmd.uop.b[4] ? src_special(cmd.uop.b, y0_ff, a1_ff, a3_ff, im_ff,
                                              hcur_ff, sixth_ff)
                                : mem[cmd.uop.b[3:0]];
      end
      if (wb_valid && !uop_ff.dst[4]) begin
         mem[uop_ff.dst[3:0]] <= wb_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff <= req_position;
         v_ff <= req_current_value;
         h_ff <= req_step_size;
      end else if (cmd.halve_h) begin
         h_ff <= {1'b0, h_ff[62:1]};
      end
      if (cmd.pass_setup) begin
         hcur_ff <= hsel;
         y0_ff   <= (cmd.pass == 2'd2) ? res_ff : v_ff;
      end
      if (cmd.div_start) begin
         div_err_ff <= cmd.div_err;
      end
      if (div_done) begin
         if (div_err_ff) begin
            err_ff <= div_q;
         end else begin
            sixth_ff <= div_q[62:0];
         end
      end
      if (wb_valid && uop_ff.dst == rk4sd_pkg::DST_RES) begin
         res_ff <= wb_data;
      end
      if (cmd.latch_whole) begin
         whole_ff <= res_ff;
      end
      if (cmd.latch_two_half) begin
         two_half_ff <= res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sat_ff <= 1'b0;
      end else if (cmd.load) begin
         sat_ff <= 1'b0;
      end else if (wb_valid && wb_sat) begin
         sat_ff <= 1'b1;
      end
   end

   assign pos_sum = sat_add(x_ff, {1'b0, h_ff});
   assign dbl_sat = (cmd.sugg == rk4sd_pkg::SUGG_DOUBLE) && h_ff[62];

   always_comb begin
      case (cmd.sugg)
         rk4sd_pkg::SUGG_DOUBLE: sugg_in = h_ff[62] ? rk4sd_pkg::STEP_MAX : {h_ff[61:0], 1'b0};
         default:                sugg_in = h_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_next_position     <= pos_sum[63:0];
         rsp_next_value        <= whole_ff;
         rsp_suggested_step    <= sugg_in;
         rsp_accepted_step     <= h_ff;
         rsp_two_half_value    <= two_half_ff;
         rsp_halving_limit_hit <= cmd.limit;
         rsp_saturated         <= sat_ff | pos_sum[64] | dbl_sat;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   assign status.uop_done = wb_valid;
   assign status.div_done = div_done;
   assign status.err_gt   = err_ff > {1'b0, tol_ff};
   assign status.err_lt   = err_ff < {6'd0, tol_ff[62:5]};
   assign status.adaptive = adapt_ff;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

endmodule

/* rtl/rk4sd_ctrl.sv */
module rk4sd_ctrl #(
   parameter int MAX_HALVINGS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  idle,
   input  rk4sd_pkg::status_type status,
   output rk4sd_pkg::cmd_type    cmd
);

   localparam int HCNT_W = $clog2(MAX_HALVINGS + 1);

   rk4sd_pkg::state_type state_ff, state_in;
   logic [1:0]                     pass_ff;
   logic [rk4sd_pkg::PC_W-1:0]     pc_ff;
   logic [HCNT_W-1:0]              halv_ff;
   logic                           limit_reached;

   assign limit_reached = (halv_ff == HCNT_W'(MAX_HALVINGS));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rk4sd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rk4sd_pkg::ST_IDLE: begin
            if (req_valid) state_in = rk4sd_pkg::ST_SETUP;
         end
         rk4sd_pkg::ST_SETUP:  state_in = rk4sd_pkg::ST_DIV6;
         rk4sd_pkg::ST_DIV6: begin
            if (status.div_done) state_in = rk4sd_pkg::ST_ISSUE;
         end
         rk4sd_pkg::ST_ISSUE:  state_in = rk4sd_pkg::ST_WAIT;
         rk4sd_pkg::ST_WAIT: begin
            if (status.uop_done) begin
               state_in = (pc_ff == rk4sd_pkg::PROG_LAST) ? rk4sd_pkg::ST_PASS_END
                                                          : rk4sd_pkg::ST_ISSUE;
            end
         end
         rk4sd_pkg::ST_PASS_END: begin
            if (pass_ff != 2'd2) begin
               state_in = rk4sd_pkg::ST_SETUP;
            end else if (status.adaptive) begin
               state_in = rk4sd_pkg::ST_ERR_DIV;
            end else begin
               state_in = rk4sd_pkg::ST_FINISH;
            end
         end
         rk4sd_pkg::ST_ERR_DIV: begin
            if (status.div_done) state_in = rk4sd_pkg::ST_DECIDE;
         end
         rk4sd_pkg::ST_DECIDE: begin
            if (status.err_gt && !limit_reached) begin
               state_in = rk4sd_pkg::ST_SETUP;
            end else begin
               state_in = rk4sd_pkg::ST_FINISH;
            end
         end
         rk4sd_pkg::ST_FINISH: begin
            if (status.out_free) state_in = rk4sd_pkg::ST_IDLE;
         end
         default: state_in = rk4sd_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pass_ff <= 2'd0;
         pc_ff   <= '0;
         halv_ff <= '0;
      end else begin
         case (state_ff)
            rk4sd_pkg::ST_IDLE: begin
               pass_ff <= 2'd0;
               halv_ff <= '0;
            end
            rk4sd_pkg::ST_DIV6: pc_ff <= '0;
            rk4sd_pkg::ST_WAIT: begin
               if (status.uop_done) pc_ff <= pc_ff + 1'b1;
            end
            rk4sd_pkg::ST_PASS_END: pass_ff <= pass_ff + 2'd1;
            rk4sd_pkg::ST_DECIDE: begin
               pass_ff <= 2'd0;
               if (status.err_gt && !limit_reached) halv_ff <= halv_ff + 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      cmd            = '0;
      cmd.pass       = pass_ff;
      cmd.uop        = rk4sd_pkg::prog_uop(pc_ff);
      cmd.sugg       = rk4sd_pkg::SUGG_KEEP;
      idle           = 1'b0;
      case (state_ff)
         rk4sd_pkg::ST_IDLE: begin
            idle     = 1'b1;
            cmd.load = req_valid;
         end
         rk4sd_pkg::ST_SETUP: begin
            cmd.pass_setup = 1'b1;
            cmd.div_start  = 1'b1;
         end
         rk4sd_pkg::ST_ISSUE: cmd.uop_start = 1'b1;
         rk4sd_pkg::ST_PASS_END: begin
            cmd.latch_whole    = (pass_ff == 2'd0);
            cmd.latch_two_half = (pass_ff == 2'd2);
            cmd.div_err        = 1'b1;
            cmd.div_start      = (pass_ff == 2'd2) && status.adaptive;
         end
         rk4sd_pkg::ST_DECIDE: cmd.halve_h = status.err_gt && !limit_reached;
         rk4sd_pkg::ST_FINISH: begin
            cmd.finish = status.out_free;
            if (status.adaptive && status.err_gt) begin
               cmd.limit = 1'b1;
            end else if (status.adaptive && status.err_lt) begin
               cmd.sugg = rk4sd_pkg::SUGG_DOUBLE;
            end
         end
         default: ;
      endcase
   end

endmodule

/* rtl/rk4_step_doubling_integrator.sv */
// channel  | handshake                  | payload
// ---------+----------------------------+------------------------------------------
// req      | req_valid / req_stall      | position, current_value, step_size
// rsp      | rsp_valid / rsp_stall      | next_position, next_value, suggested_step,
//          |                            | accepted_step, two_half_value, flags
// csr      | csr_valid / csr_ready      | csr_index, csr_wdata (ready always high)
//
// One transaction is worked through at a time by a sequencer over a shared
// 32x32 multiplier and a reciprocal-multiply constant divider. An RK4 pass
// is 42 ops (24 multiplies, 18 adds and negations) plus setup, so an attempt
// is three passes, plus the error check in adaptive mode. A transaction takes
// (1 + halvings) attempts, at most MAX_HALVINGS + 1. Synchronous active-high
// reset.
// A stalled result sits in the output register while the next transaction
// is accepted; the finish step waits only if that register is still full.
module rk4_step_doubling_integrator #(
   parameter int MAX_HALVINGS = 32,
   parameter int FRAC_BITS    = 48
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [63:0] req_position,
   input  logic signed [63:0] req_current_value,
   input  logic [62:0]        req_step_size,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [63:0] rsp_next_position,
   output logic signed [63:0] rsp_next_value,
   output logic [62:0]        rsp_suggested_step,
   output logic [62:0]        rsp_accepted_step,
   output logic signed [63:0] rsp_two_half_value,
   output logic               rsp_halving_limit_hit,
   output logic               rsp_saturated,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [63:0]        csr_wdata
);

   rk4sd_pkg::cmd_type    cmd;
   rk4sd_pkg::status_type status;
   logic                  idle;

   assign req_stall = !idle;
   assign csr_ready = 1'b1;

   rk4sd_ctrl #(.MAX_HALVINGS(MAX_HALVINGS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .idle      (idle),
      .status    (status),
      .cmd       (cmd)
   );

   rk4sd_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .req_position          (req_position),
      .req_current_value     (req_current_value),
      .req_step_size         (req_step_size),
      .csr_valid             (csr_valid && csr_ready),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_next_position     (rsp_next_position),
      .rsp_next_value        (rsp_next_value),
      .rsp_suggested_step    (rsp_suggested_step),
      .rsp_accepted_step     (rsp_accepted_step),
      .rsp_two_half_value    (rsp_two_half_value),
      .rsp_halving_limit_hit (rsp_halving_limit_hit),
      .rsp_saturated         (rsp_saturated)
   );

endmodule

/* tb/sv/tb_rk4_step_doubling_integrator.sv */
`timescale 1ns / 100ps

module tb_rk4_step_doubling_integrator;

   localparam int HALVING_CAP = 32;
   localparam int NORMAL_ITEMS = 45;
   localparam int HEAVY_ITEMS = 3;
   localparam int PHASES = 24;
   localparam logic signed [63:0] SMAX = rk4sd_pkg::WORD_MAX;
   localparam logic signed [63:0] SMIN = rk4sd_pkg::WORD_MIN;
   localparam logic signed [63:0] ONE = 64'sd281474976710656;

   typedef struct {
      logic signed [63:0] next_position;
      logic signed [63:0] next_value;
      logic [62:0]        suggested_step;
      logic [62:0]        accepted_step;
      logic signed [63:0] two_half_value;
      logic               limit_hit;
      logic               saturated;
   } integ_result_type;

   typedef struct {
      logic signed [63:0] x;
      logic signed [63:0] v;
      logic [62:0]        h;
      bit                 typed;
      integ_result_type   res;
   } point_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [63:0] req_position = '0;
   logic signed [63:0] req_current_value = '0;
   logic [62:0]        req_step_size = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [63:0] rsp_next_position;
   logic signed [63:0] rsp_next_value;
   logic [62:0]        rsp_suggested_step;
   logic [62:0]        rsp_accepted_step;
   logic signed [63:0] rsp_two_half_value;
   logic               rsp_halving_limit_hit;
   logic               rsp_saturated;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [2:0]         csr_index = '0;
   logic [63:0]        csr_wdata = '0;

   logic signed [63:0] lin_coeff;
   logic signed [63:0] cub_coeff;
   logic signed [63:0] inv_mass;
   logic [62:0]        tolerance;
   logic               adaptive;
   bit                 sat_flag;

   integ_result_type pending_results[$];
   int unsigned mismatches = 0;
   int          burst_left = 0;

   rk4_step_doubling_integrator dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #(64'd400_000_000);
      $display("simulation failed");
      $finish;
   end

   // ---------------- predictor ----------------
   function automatic logic signed [63:0] sat_add(logic signed [63:0] a, logic signed [63:0] b);
      logic [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) begin
         sat_flag = 1'b1;
         return s[64] ? SMIN : SMAX;
      end
      return s[63:0];
   endfunction

   function automatic logic signed [63:0] sat_neg(logic signed [63:0] a);
      if (a == SMIN) begin
         sat_flag = 1'b1;
         return SMAX;
      end
      return -a;
   endfunction

   function automatic logic signed [63:0] fix_mul(logic signed [63:0] a, logic signed [63:0] b);
      logic [63:0]  ma, mb, q;
      logic [127:0] p;
      bit           neg;
      ma = a[63] ? 64'd0 - a : a;
      mb = b[63] ? 64'd0 - b : b;
      neg = a[63] != b[63];
      p = {64'd0, ma} * {64'd0, mb};
      if (p[127:112] != '0) begin
         sat_flag = 1'b1;
         return neg ? SMIN : SMAX;
      end
      q = p[111:48];
      if (neg) begin
         if (q > 64'h8000_0000_0000_0000) begin
            sat_flag = 1'b1;
            return SMIN;
         end
         return 64'd0 - q;
      end
      if (q > 64'h7FFF_FFFF_FFFF_FFFF) begin
         sat_flag = 1'b1;
         return SMAX;
      end
      return q;
   endfunction

   function automatic logic signed [63:0] slope(logic signed [63:0] y);
      logic signed [63:0] y3, t;
      y3 = fix_mul(fix_mul(y, y), y);
      t = sat_add(fix_mul(lin_coeff, y), fix_mul(cub_coeff, y3));
      return fix_mul(sat_neg(t), inv_mass);
   endfunction

   function automatic logic signed [63:0] rk4_advance(logic [62:0] h, logic signed [63:0] y);
      logic signed [63:0] hs, half, sixth, k1, k2, k3, k4, sum;
      hs = {1'b0, h};
      half = {2'b0, h[62:1]};
      sixth = {1'b0, h / 63'd6};
      k1 = slope(y);
      k2 = slope(sat_add(y, fix_mul(half, k1)));
      k3 = slope(sat_add(y, fix_mul(half, k2)));
      k4 = slope(sat_add(y, fix_mul(hs, k3)));
      sum = sat_add(sat_add(k1, sat_add(k2, k2)), sat_add(sat_add(k3, k3), k4));
      return sat_add(y, fix_mul(sixth, sum));
   endfunction

   function automatic integ_result_type predict_point(logic signed [63:0] x,
                                                      logic signed [63:0] v,
                                                      logic [62:0] h0);
      integ_result_type r;
      logic [62:0] h, sugg;
      logic signed [63:0] whole, th;
      logic [63:0] mag, err;
      int halvings;
      bit limit;
      h = h0;
      halvings = 0;
      limit = 0;
      sat_flag = 0;
      while (1'b1) begin
         whole = rk4_advance(h, v);
         th = rk4_advance(h >> 1, rk4_advance(h >> 1, v));
         if (!adaptive) begin
            sugg = h;
            break;
         end
         mag = (th >= whole) ? th - whole : whole - th;
         err = mag / 64'd15;
         if (err > {1'b0, tolerance}) begin
            if (halvings >= HALVING_CAP) begin
               limit = 1;
               sugg = h;
               break;
            end
            h = h >> 1;
            halvings++;
            continue;
         end
         if (err < {6'd0, tolerance[62:5]}) begin
            if (h > (rk4sd_pkg::STEP_MAX >> 1)) begin
               sat_flag = 1'b1;
               sugg = rk4sd_pkg::STEP_MAX;
            end else begin
               sugg = h << 1;
            end
         end else begin
            sugg = h;
         end
         break;
      end
      r.next_position = sat_add(x, {1'b0, h});
      r.next_value = whole;
      r.suggested_step = sugg;
      r.accepted_step = h;
      r.two_half_value = th;
      r.limit_hit = limit;
      r.saturated = sat_flag;
      return r;
   endfunction

   // ---------------- checking ----------------
   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      mismatches++;
      $display("%0t: %s got %h expected %h", $realtime, what, got, want);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected transaction", rsp_next_value, '0);
         end else begin
            integ_result_type e;
            e = pending_results.pop_front();
            if (rsp_next_position !== e.next_position)
               report_mismatch("next_position", rsp_next_position, e.next_position);
            if (rsp_next_value !== e.next_value)
               report_mismatch("next_value", rsp_next_value, e.next_value);
            if (rsp_suggested_step !== e.suggested_step)
               report_mismatch("suggested_step", 64'(rsp_suggested_step),
                               64'(e.suggested_step));
            if (rsp_accepted_step !== e.accepted_step)
               report_mismatch("accepted_step", 64'(rsp_accepted_step),
                               64'(e.accepted_step));
            if (rsp_two_half_value !== e.two_half_value)
               report_mismatch("two_half_value", rsp_two_half_value, e.two_half_value);
            if (rsp_halving_limit_hit !== e.limit_hit)
               report_mismatch("halving_limit_hit", 64'(rsp_halving_limit_hit),
                               64'(e.limit_hit));
            if (rsp_saturated !== e.saturated)
               report_mismatch("saturated", 64'(rsp_saturated), 64'(e.saturated));
         end
      end
   end

   // receiver stall pattern: runs of free flow, random and mostly stalled
   int stall_mode = 0;
   int stall_run = 0;
   always @(negedge clock) begin
      if (stall_run == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_run = $urandom_range(5, 300);
      end
      stall_run--;
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= 1'($urandom_range(0, 1));
         default: rsp_stall <= ($urandom_range(0, 3) != 0);
      endcase
   end

   // ---------------- drivers ----------------
   task automatic csr_write(logic [2:0] idx, logic [63:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         rk4sd_pkg::CSR_LINEAR:   lin_coeff = data;
         rk4sd_pkg::CSR_CUBIC:    cub_coeff = data;
         rk4sd_pkg::CSR_INV_MASS: inv_mass = data;
         rk4sd_pkg::CSR_TOL:      tolerance = data[62:0];
         rk4sd_pkg::CSR_ADAPTIVE: adaptive = data[0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic configure(logic signed [63:0] a1, logic signed [63:0] a3,
                            logic signed [63:0] im, logic [62:0] tol, logic ad);
      while (pending_results.size() != 0) @(posedge clock);
      csr_write(rk4sd_pkg::CSR_LINEAR, a1);
      csr_write(rk4sd_pkg::CSR_CUBIC, a3);
      csr_write(rk4sd_pkg::CSR_INV_MASS, im);
      csr_write(rk4sd_pkg::CSR_TOL, {$urandom_range(0, 1) == 1, tol});
      csr_write(rk4sd_pkg::CSR_ADAPTIVE, {{63{1'b1}}, ad});
      csr_write(3'($urandom_range(5, 7)), {$urandom, $urandom});
   endtask

   task automatic send_point(logic signed [63:0] x, logic signed [63:0] v, logic [62:0] h,
                             integ_result_type want);
      int gap;
      @(negedge clock);
      req_valid <= 1'b1;
      req_position <= x;
      req_current_value <= v;
      req_step_size <= h;
      do @(posedge clock); while (req_stall);
      pending_results.push_back(want);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 8);
         gap = $urandom_range(1, 6);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   function automatic logic signed [63:0] rnd_word();
      return {$urandom, $urandom};
   endfunction

   function automatic logic signed [63:0] rnd_value();
      if ($urandom_range(0, 7) == 0) return rnd_word();
      return rnd_word() >>> 13;
   endfunction

   function automatic logic [62:0] rnd_step();
      case ($urandom_range(0, 15))
         0: return '0;
         1, 2: return 63'(rnd_word());
         default: return 63'({$urandom_range(0, 4095), $urandom});
      endcase
   endfunction

   function automatic integ_result_type known(logic signed [63:0] np, logic signed [63:0] nv,
                                              logic [62:0] sg, logic [62:0] ac,
                                              logic signed [63:0] th, logic sat);
      integ_result_type r;
      r.next_position = np;
      r.next_value = nv;
      r.suggested_step = sg;
      r.accepted_step = ac;
      r.two_half_value = th;
      r.limit_hit = 1'b0;
      r.saturated = sat;
      return r;
   endfunction

   point_row_type directed[$];

   initial begin
      point_row_type row;
      integ_result_type want;
      int kind, count;
      logic signed [63:0] x, v;
      logic [62:0] h;

      // reset values
      lin_coeff = '0;
      cub_coeff = '0;
      inv_mass = rk4sd_pkg::RST_INV_MASS;
      tolerance = rk4sd_pkg::RST_TOL;
      adaptive = 1'b1;

      // zero coefficients after reset: value passes through, step doubles, saturating at STEP_MAX
      directed.push_back('{64'sd0, 64'sd0, 63'd1, 1,
                           known(64'sd1, 64'sd0, 63'd2, 63'd1, 64'sd0, 0)});
      directed.push_back('{SMAX, SMAX, 63'd1, 1, known(SMAX, SMAX, 63'd2, 63'd1, SMAX, 1)});
      directed.push_back('{SMIN, SMIN, rk4sd_pkg::STEP_MAX, 1,
                           known(-64'sd1, SMIN, rk4sd_pkg::STEP_MAX, rk4sd_pkg::STEP_MAX,
                                 SMIN, 1)});
      directed.push_back('{64'sd5, ONE, 63'd0, 1, known(64'sd5, ONE, 63'd0, 63'd0, ONE, 0)});
      directed.push_back('{-64'sd1, -ONE, rk4sd_pkg::STEP_MAX >> 1, 1,
                           known(64'sd4611686018427387902, -ONE, rk4sd_pkg::STEP_MAX - 63'd1,
                                 rk4sd_pkg::STEP_MAX >> 1, -ONE, 0)});
      directed.push_back('{64'sd0, ONE, (rk4sd_pkg::STEP_MAX >> 1) + 63'd1, 1,
                           known(64'sd4611686018427387904, ONE, rk4sd_pkg::STEP_MAX,
                                 (rk4sd_pkg::STEP_MAX >> 1) + 63'd1, ONE, 1)});
      directed.push_back('{64'h5555_5555_5555_5555, 64'sd3, 63'h2AAA_AAAA_AAAA_AAAA, 0,
                           want});
      directed.push_back('{64'h2AAA_AAAA_AAAA_AAAA, -64'sd3, 63'h5555_5555_5555_5555, 0,
                           want});

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed[i]) begin
         row = directed[i];
         want = row.typed ? row.res : predict_point(row.x, row.v, row.h);
         send_point(row.x, row.v, row.h, want);
      end

      // sender holds off until the block has drained
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);

      for (int p = 0; p < PHASES; p++) begin
         kind = p % 6;
         count = NORMAL_ITEMS;
         case (kind)
            0: configure(rnd_word() >>> 14, rnd_word() >>> 16, rnd_word() >>> 15,
                         63'($urandom_range(1000, 1 << 30)), 1'b1);
            1: configure(rnd_word(), rnd_word(), rnd_word(), 63'(rnd_word()), 1'b0);
            2: begin
               configure(SMAX, SMIN, SMIN, '0, 1'b1);
               count = HEAVY_ITEMS;
            end
            3: configure('0, '0, ONE, rk4sd_pkg::STEP_MAX, 1'b1);
            4: configure(SMIN, SMAX, SMAX, 63'd1, 1'b0);
            default: begin
               configure(rnd_word() >>> 12, rnd_word() >>> 12, rnd_word() >>> 12, '0, 1'b1);
               count = HEAVY_ITEMS;
            end
         endcase
         for (int n = 0; n < count; n++) begin
            x = rnd_word();
            v = rnd_value();
            h = rnd_step();
            send_point(x, v, h, predict_point(x, v, h));
         end
         @(negedge clock);
         req_valid <= 1'b0;
      end

      while (pending_results.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
